@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define AST_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, ignored while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Same-cycle implication that is checked during reset as well.
`define AST_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

@@ sv/tgt_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch gesture tracker package
// Widths, register indexes and reset values shared by the tracker files.
// ----------------------------------------------------------------------------
`default_nettype none

package tgt_pkg;

   // Electrode count default and field widths.
   localparam int ELECTRODES_DEF = 12;
   localparam int WORD_W         = 12;
   localparam int TIME_W         = 32;
   localparam int QUERY_W        = 4;
   localparam int DELAY_W        = 16;

   // Stream payload widths.
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 80;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_MAP    = 2'd0,
      CSR_DOUBLE_TAP_MS = 2'd1,
      CSR_LONG_TOUCH_MS = 2'd2,
      CSR_DURATIONS_EN  = 2'd3
   } csr_index_type;

   // Register reset values.
   localparam logic [WORD_W-1:0]  SENSOR_MAP_RST    = 12'hFFF;
   localparam logic [DELAY_W-1:0] DOUBLE_TAP_MS_RST = 16'd300;
   localparam logic [DELAY_W-1:0] LONG_TOUCH_MS_RST = 16'd1000;
   localparam logic               DURATIONS_EN_RST  = 1'b1;

endpackage

`default_nettype wire

@@ sv/touch_gesture_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// Touch gesture tracker
// Per-poll touch, change, double-tap and long-touch flags and the queried touch duration for an electrode bank.
// ----------------------------------------------------------------------------
// Each request beat is one poll and yields exactly one response beat. A poll
// is captured into an input register, evaluated by one pass of per-electrode
// compare and subtract logic, and written to an output register together with
// the state update, so the block takes a poll in every cycle while the response
// side is ready, and a response passes through the input and output registers.
// The output register and the input register together let a new poll be taken
// while the previous response is still waiting. Configuration writes are
// accepted at any time and take effect on the next poll evaluated.
`default_nettype none

module touch_gesture_tracker_unit #(
   parameter int ELECTRODES = tgt_pkg::ELECTRODES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream.
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // status_word [11:0], now_ms [43:12], query_sensor [47:44]
   input  wire logic [tgt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // new_status [0]
   input  wire logic                             req_tuser,
   // Response stream.
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // touched_mask [11:0], changed_mask [23:12], double_tap_mask [35:24],
   // long_touch_mask [47:36], touch_duration [79:48]
   output      logic [tgt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status_taken [0]
   output      logic                             rsp_tuser,
   // Configuration write channel.
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tgt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tgt_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int WORD_W  = tgt_pkg::WORD_W;
   localparam int TIME_W  = tgt_pkg::TIME_W;
   localparam int QUERY_W = tgt_pkg::QUERY_W;
   localparam int DELAY_W = tgt_pkg::DELAY_W;
   localparam int EXT_W   = (ELECTRODES > WORD_W) ? ELECTRODES : WORD_W;

   // Configuration registers.
   logic [WORD_W-1:0]  sensor_map_ff, sensor_map_in;
   logic [DELAY_W-1:0] dbl_ms_ff, dbl_ms_in;
   logic [DELAY_W-1:0] long_ms_ff, long_ms_in;
   logic               dur_en_ff, dur_en_in;

   // Input and output stages.
   logic                            in_vld_ff, in_vld_in;
   logic [tgt_pkg::REQ_TDATA_W-1:0] in_data_ff, in_data_in;
   logic                            in_user_ff, in_user_in;
   logic                            out_vld_ff, out_vld_in;
   logic [tgt_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                            out_user_ff, out_user_in;

   // Tracker state.
   logic [WORD_W-1:0] cur_touch_ff, cur_touch_in;
   logic [WORD_W-1:0] prev_touch_ff, prev_touch_in;
   logic [EXT_W-1:0]  prior_touch_ff, prior_touch_in;
   logic [EXT_W-1:0]  prior_change_ff, prior_change_in;
   logic [TIME_W-1:0] tap_time_ff [ELECTRODES];
   logic [TIME_W-1:0] tap_time_in [ELECTRODES];
   logic [TIME_W-1:0] touch_time_ff [ELECTRODES];
   logic [TIME_W-1:0] touch_time_in [ELECTRODES];

   // Poll fields and per-electrode working signals.
   logic               fresh;
   logic [WORD_W-1:0]  word;
   logic [TIME_W-1:0]  now;
   logic [QUERY_W-1:0] query;
   logic               advance;
   logic [EXT_W-1:0]   cur_new_ext;
   logic [EXT_W-1:0]   cur_old_ext;
   logic [EXT_W-1:0]   map_ext;
   logic [EXT_W-1:0]   touched_vec;
   logic [EXT_W-1:0]   changed_vec;
   logic [EXT_W-1:0]   dbl_vec;
   logic [EXT_W-1:0]   lng_vec;
   logic [TIME_W-1:0]  tap_age [ELECTRODES];
   logic [TIME_W-1:0]  sel_time;
   logic               sel_touch;
   logic               sel_hit;
   logic [TIME_W-1:0]  duration;

   // Handshake outputs.
   assign advance    = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign csr_ready  = 1'b1;

   // Unpack the captured poll.
   assign fresh = in_user_ff;
   assign word  = in_data_ff[WORD_W-1:0];
   assign now   = in_data_ff[WORD_W+TIME_W-1:WORD_W];
   assign query = in_data_ff[WORD_W+TIME_W+QUERY_W-1:WORD_W+TIME_W];

   // Configuration writes.
   always_comb begin
      sensor_map_in = sensor_map_ff;
      dbl_ms_in     = dbl_ms_ff;
      long_ms_in    = long_ms_ff;
      dur_en_in     = dur_en_ff;
      if (csr_valid) begin
         case (tgt_pkg::csr_index_type'(csr_index))
            tgt_pkg::CSR_SENSOR_MAP:    sensor_map_in = csr_data[WORD_W-1:0];
            tgt_pkg::CSR_DOUBLE_TAP_MS: dbl_ms_in     = csr_data;
            tgt_pkg::CSR_LONG_TOUCH_MS: long_ms_in    = csr_data;
            tgt_pkg::CSR_DURATIONS_EN:  dur_en_in     = csr_data[0];
            default:                    dur_en_in     = dur_en_ff;
         endcase
      end
   end

   // Stage valid bits and payload capture.
   always_comb begin
      in_data_in  = in_data_ff;
      in_user_in  = in_user_ff;
      in_vld_in   = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in  = 1'b1;
         in_data_in = req_tdata;
         in_user_in = req_tuser;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // Touch words: previous follows current on each evaluated poll, current takes fresh words.
   always_comb begin
      prev_touch_in = prev_touch_ff;
      cur_touch_in  = cur_touch_ff;
      if (advance) begin
         prev_touch_in = cur_touch_ff;
         if (fresh) begin
            cur_touch_in = word;
         end
      end
      cur_old_ext = EXT_W'(cur_touch_ff);
      cur_new_ext = fresh ? EXT_W'(word) : EXT_W'(cur_touch_ff);
      map_ext     = EXT_W'(sensor_map_ff);
   end

   // Per-electrode touch start and hold length times.
   always_comb begin
      for (int i = 0; i < ELECTRODES; i++) begin
         touch_time_in[i] = touch_time_ff[i];
         if (fresh && dur_en_ff) begin
            if (cur_new_ext[i] && !cur_old_ext[i]) begin
               touch_time_in[i] = now;
            end else if (!cur_new_ext[i] && cur_old_ext[i]) begin
               touch_time_in[i] = now - touch_time_ff[i];
            end
         end
      end
   end

   // Gesture flags and tap time updates for mapped electrodes.
   always_comb begin
      touched_vec     = '0;
      changed_vec     = '0;
      dbl_vec         = '0;
      lng_vec         = '0;
      prior_touch_in  = prior_touch_ff;
      prior_change_in = prior_change_ff;
      for (int i = 0; i < ELECTRODES; i++) begin
         tap_age[i]     = now - tap_time_ff[i];
         tap_time_in[i] = tap_time_ff[i];
         if (map_ext[i]) begin
            touched_vec[i] = cur_new_ext[i];
            changed_vec[i] = cur_new_ext[i] ^ cur_old_ext[i];
            if (prior_touch_ff[i] && prior_change_ff[i]) begin
               dbl_vec[i]     = tap_age[i] < TIME_W'(dbl_ms_ff);
               tap_time_in[i] = now;
            end
            if (prior_touch_ff[i] && !prior_change_ff[i] &&
                (tap_time_ff[i] != '0) && (tap_age[i] > TIME_W'(long_ms_ff))) begin
               lng_vec[i]     = 1'b1;
               tap_time_in[i] = '0;
            end
            prior_touch_in[i]  = cur_new_ext[i];
            prior_change_in[i] = cur_new_ext[i] ^ cur_old_ext[i];
         end
      end
   end

   // Duration of the queried electrode.
   always_comb begin
      sel_time  = '0;
      sel_touch = 1'b0;
      sel_hit   = 1'b0;
      for (int i = 0; i < ELECTRODES; i++) begin
         if (query == QUERY_W'(i)) begin
            sel_time  = touch_time_in[i];
            sel_touch = cur_new_ext[i];
            sel_hit   = 1'b1;
         end
      end
      duration = '0;
      if (dur_en_ff && sel_hit) begin
         duration = sel_touch ? (now - sel_time) : sel_time;
      end
   end

   // Response payload.
   always_comb begin
      out_data_in = out_data_ff;
      out_user_in = out_user_ff;
      if (advance) begin
         out_user_in = fresh;
         out_data_in = {duration,
                        lng_vec[WORD_W-1:0],
                        dbl_vec[WORD_W-1:0],
                        changed_vec[WORD_W-1:0],
                        touched_vec[WORD_W-1:0]};
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_user_ff  <= in_user_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      if (reset) begin
         sensor_map_ff   <= tgt_pkg::SENSOR_MAP_RST;
         dbl_ms_ff       <= tgt_pkg::DOUBLE_TAP_MS_RST;
         long_ms_ff      <= tgt_pkg::LONG_TOUCH_MS_RST;
         dur_en_ff       <= tgt_pkg::DURATIONS_EN_RST;
         in_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
         cur_touch_ff    <= '0;
         prev_touch_ff   <= '0;
         prior_touch_ff  <= '0;
         prior_change_ff <= '0;
         for (int i = 0; i < ELECTRODES; i++) begin
            tap_time_ff[i]   <= '0;
            touch_time_ff[i] <= '0;
         end
      end else begin
         sensor_map_ff <= sensor_map_in;
         dbl_ms_ff     <= dbl_ms_in;
         long_ms_ff    <= long_ms_in;
         dur_en_ff     <= dur_en_in;
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         cur_touch_ff  <= cur_touch_in;
         prev_touch_ff <= prev_touch_in;
         if (advance) begin
            prior_touch_ff  <= prior_touch_in;
            prior_change_ff <= prior_change_in;
            for (int i = 0; i < ELECTRODES; i++) begin
               tap_time_ff[i]   <= tap_time_in[i];
               touch_time_ff[i] <= touch_time_in[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/tgt_checker.sv @@
// ----------------------------------------------------------------------------
// Touch gesture tracker checker
// Port-level assertions on the tracker, attached to the tracker module by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tgt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [tgt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                             rsp_tuser
);

   logic [tgt_pkg::WORD_W-1:0] dbl_mask;
   logic [tgt_pkg::WORD_W-1:0] lng_mask;

   assign dbl_mask = rsp_tdata[3*tgt_pkg::WORD_W-1:2*tgt_pkg::WORD_W];
   assign lng_mask = rsp_tdata[4*tgt_pkg::WORD_W-1:3*tgt_pkg::WORD_W];

   // The response stage is empty in the cycle after a reset cycle.
   `AST_ALWAYS(a_rsp_idle_after_reset, clock, reset, ##1 !rsp_tvalid)

   // The request side only stalls when a response is held by the consumer.
   `AST_SAME(a_req_stall_needs_rsp, clock, reset, !req_tready, rsp_tvalid)

   // A tap and a hold are exclusive, so no electrode flags both gestures.
   `AST_SAME(a_gestures_exclusive, clock, reset, rsp_tvalid, (dbl_mask & lng_mask) == '0)

   // A stalled response beat keeps its payload.
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind touch_gesture_tracker_unit tgt_checker u_tgt_checker (.*);

`default_nettype wire
